### sv/tcc_pkg.sv
// shared constants and types for the transitive closure compare block
package tcc_pkg;

    // default vertex count, legal range 2 to 32
    localparam int NODES_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int NODE_W   = 5;

    // action codes of an input word
    localparam logic [ACTION_W-1:0] ACT_ADD_A = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EVAL  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic edge_wr_a;
        logic edge_wr_b;
        logic row_rd;
        logic krow_cap;
        logic row_wr;
        logic cmp_start;
        logic cmp_step;
        logic load_out;
        logic clear_all;
    } cmd_t;

endpackage

### sv/tcc_ctrl.sv
// controller: sequences edge loading, the closure sweep, the compare and the result hand-off
module tcc_ctrl
    import tcc_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [ACTION_W-1:0]         action,
    input  logic                        out_stall,
    output logic                        in_stall,
    output logic                        out_valid,
    output cmd_t                        cmd,
    output logic [$clog2(NODES)-1:0]    rd_addr,
    output logic [$clog2(NODES)-1:0]    wr_addr,
    output logic [$clog2(NODES)-1:0]    k_addr
);

    localparam int IW = $clog2(NODES);
    localparam logic [IW-1:0] LAST = IW'(NODES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KRD  = 3'd1;
    localparam logic [2:0] S_KCAP = 3'd2;
    localparam logic [2:0] S_ROW  = 3'd3;
    localparam logic [2:0] S_CRD  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] i_reg, i_next;
    logic          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        out_valid_next = out_valid_reg & out_stall;
        cmd            = '0;
        rd_addr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action)
                        ACT_ADD_A: cmd.edge_wr_a = 1'b1;
                        ACT_ADD_B: cmd.edge_wr_b = 1'b1;
                        ACT_EVAL:
                        begin
                            k_next     = '0;
                            state_next = S_KRD;
                        end
                        default: ;
                    endcase
                end
            end
            S_KRD:
            begin
                cmd.row_rd = 1'b1;
                rd_addr    = k_reg;
                state_next = S_KCAP;
            end
            S_KCAP:
            begin
                cmd.krow_cap = 1'b1;
                cmd.row_rd   = 1'b1;
                rd_addr      = '0;
                i_next       = '0;
                state_next   = S_ROW;
            end
            S_ROW:
            begin
                cmd.row_wr = 1'b1;
                if (i_reg != LAST)
                begin
                    cmd.row_rd = 1'b1;
                    rd_addr    = i_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                end
                else if (k_reg == LAST)
                begin
                    state_next = S_CRD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_KRD;
                end
            end
            S_CRD:
            begin
                cmd.row_rd    = 1'b1;
                cmd.cmp_start = 1'b1;
                rd_addr       = '0;
                i_next        = '0;
                state_next    = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (i_reg != LAST)
                begin
                    cmd.row_rd = 1'b1;
                    rd_addr    = i_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.clear_all  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign wr_addr   = i_reg;
    assign k_addr    = k_reg;

endmodule

### sv/tcc_dp.sv
// datapath: the two reach matrices, row update, row compare and result register
module tcc_dp
    import tcc_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    input  logic [NODE_W-1:0]           src_node,
    input  logic [NODE_W-1:0]           dst_node,
    input  logic [$clog2(NODES)-1:0]    rd_addr,
    input  logic [$clog2(NODES)-1:0]    wr_addr,
    input  logic [$clog2(NODES)-1:0]    k_addr,
    output logic                        equivalent
);

    localparam int IW = $clog2(NODES);
    localparam logic [NODE_W+1:0] NODES_W = (NODE_W + 2)'(NODES);

    logic [NODES-1:0] mem_a [NODES];
    logic [NODES-1:0] mem_b [NODES];
    logic [NODES-1:0] vld_a_reg;
    logic [NODES-1:0] vld_b_reg;

    logic [NODES-1:0] a_rd_reg, b_rd_reg;
    logic             a_rdv_reg, b_rdv_reg;
    logic [NODES-1:0] krow_a_reg, krow_b_reg;
    logic             same_reg;
    logic             equivalent_reg;

    logic             edge_ok;
    logic [IW-1:0]    src_idx, dst_idx;
    logic [NODES-1:0] dst_hot;
    logic [NODES-1:0] row_a, row_b, closed_a, closed_b;

    logic             wr_en_a, wr_en_b;
    logic [IW-1:0]    wr_addr_a, wr_addr_b;
    logic [NODES-1:0] wr_data_a, wr_data_b, wr_mask_a, wr_mask_b;

    // edges past the vertex count are dropped
    assign edge_ok = ({2'b00, src_node} < NODES_W) && ({2'b00, dst_node} < NODES_W);
    assign src_idx = IW'(src_node);
    assign dst_idx = IW'(dst_node);
    assign dst_hot = NODES'(1) << dst_idx;

    // a row never written since the last clear reads as zero
    assign row_a = a_rdv_reg ? a_rd_reg : '0;
    assign row_b = b_rdv_reg ? b_rd_reg : '0;

    assign closed_a = row_a | (row_a[k_addr] ? krow_a_reg : '0);
    assign closed_b = row_b | (row_b[k_addr] ? krow_b_reg : '0);

    // edge into a stale row rewrites the whole row
    assign wr_en_a   = (cmd.edge_wr_a & edge_ok) | cmd.row_wr;
    assign wr_addr_a = cmd.row_wr ? wr_addr : src_idx;
    assign wr_data_a = cmd.row_wr ? closed_a : dst_hot;
    assign wr_mask_a = (cmd.row_wr || !vld_a_reg[src_idx]) ? '1 : dst_hot;

    assign wr_en_b   = (cmd.edge_wr_b & edge_ok) | cmd.row_wr;
    assign wr_addr_b = cmd.row_wr ? wr_addr : src_idx;
    assign wr_data_b = cmd.row_wr ? closed_b : dst_hot;
    assign wr_mask_b = (cmd.row_wr || !vld_b_reg[src_idx]) ? '1 : dst_hot;

    always_ff @(posedge clk)
    begin
        if (wr_en_a)
        begin
            for (int b = 0; b < NODES; b++)
            begin
                if (wr_mask_a[b])
                begin
                    mem_a[wr_addr_a][b] <= wr_data_a[b];
                end
            end
        end
        if (cmd.row_rd)
        begin
            a_rd_reg  <= mem_a[rd_addr];
            a_rdv_reg <= vld_a_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_b)
        begin
            for (int b = 0; b < NODES; b++)
            begin
                if (wr_mask_b[b])
                begin
                    mem_b[wr_addr_b][b] <= wr_data_b[b];
                end
            end
        end
        if (cmd.row_rd)
        begin
            b_rd_reg  <= mem_b[rd_addr];
            b_rdv_reg <= vld_b_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= '0;
            vld_b_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            vld_a_reg <= '0;
            vld_b_reg <= '0;
        end
        else
        begin
            if (wr_en_a)
            begin
                vld_a_reg[wr_addr_a] <= 1'b1;
            end
            if (wr_en_b)
            begin
                vld_b_reg[wr_addr_b] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.krow_cap)
        begin
            krow_a_reg <= row_a;
            krow_b_reg <= row_b;
        end
        if (cmd.cmp_start)
        begin
            same_reg <= 1'b1;
        end
        else if (cmd.cmp_step)
        begin
            same_reg <= same_reg & (row_a == row_b);
        end
        if (cmd.load_out)
        begin
            equivalent_reg <= same_reg;
        end
    end

    assign equivalent = equivalent_reg;

endmodule

### sv/transitive_closure_compare.sv
// top level: compares the transitive closures of two directed graphs
// usage:
//   input channel (in_valid / in_stall) carries one word per edge or command:
//   action 0 adds edge src_node -> dst_node to the first graph, action 1 to
//   the second, action 2 closes both graphs, compares them and clears them,
//   action 3 is taken and ignored. edges with an index of NODES or more are
//   dropped.
//   output channel (out_valid / out_stall) carries one word per evaluate:
//   equivalent is 1 when both closures hold the same reach bits.
// timing:
//   edge words stream in back to back.
//   an evaluate word holds in_stall high through the whole sweep: per pivot
//   one row-k fetch, one capture and NODES row read-modify-writes through
//   the single read and write port of each matrix memory, then the row
//   compare over all NODES rows and one hand-off.
//   the result shows on out_valid in the cycle after the hand-off.
// reset and stall:
//   reset empties both graphs through per-row valid bits, which an evaluate
//   also clears at its hand-off. a stalled result word holds; edges are still
//   taken behind it, and the next evaluate waits at its hand-off until the
//   output register is free.
module transitive_closure_compare
    import tcc_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [NODE_W-1:0]   src_node,
    input  logic [NODE_W-1:0]   dst_node,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                equivalent
);

    localparam int IW = $clog2(NODES);

    cmd_t          cmd;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] k_addr;

    // sequencer: pivot and row counters, handshakes
    tcc_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .k_addr    (k_addr)
    );

    // matrices, row or-update, compare and result register
    tcc_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .src_node   (src_node),
        .dst_node   (dst_node),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .k_addr     (k_addr),
        .equivalent (equivalent)
    );

    // an accepted evaluate word starts the closure sweep at once
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == ACT_EVAL |=> in_stall)
        else $error("evaluate word did not start the closure sweep");

    // a fresh result only follows a sweep
    a_result_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word appeared without an evaluate");

    // hand-off of a result returns the block to taking words
    a_handoff_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid && !in_stall)
        else $error("result hand-off did not leave the block idle");

    // edge writes happen only while the input side is open
    a_edge_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.edge_wr_a || cmd.edge_wr_b) |-> !in_stall && in_valid && !cmd.row_wr)
        else $error("edge write outside an accepted edge word");

endmodule

### bench/transitive_closure_compare_tb.sv
// self-checking bench for the transitive closure compare block
`timescale 1ns / 1ps

module transitive_closure_compare_tb;
    import tcc_pkg::*;

    localparam int NODES = NODES_DEF;
    // clock cycles that one evaluate holds the input stalled
    localparam int EVAL_CYCLES = (NODES + 1) * (NODES + 2);
    localparam int MAX_WAIT = 16;
    localparam int RANDOM_WORDS = 400;
    localparam int MIN_EVALS = 40;

    // the one action code the block takes and drops
    localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

    typedef logic [NODES-1:0] reach_row_t;

    // one directed word: payload plus an optional typed-in result
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [NODE_W-1:0]   src;
        logic [NODE_W-1:0]   dst;
        logic                typed;
        logic                value;
    } dir_word_t;

    typedef struct packed {
        logic typed;
        logic value;
    } typed_equiv_t;

    localparam int DIR_N = 26;
    localparam dir_word_t DIRECTED [DIR_N] = '{
        // empty graphs straight after reset
        '{ACT_EVAL,    5'd0,  5'd0,  1'b1, 1'b1},
        // one extreme edge in the first graph only
        '{ACT_ADD_A,   5'd0,  5'd31, 1'b0, 1'b0},
        '{ACT_EVAL,    5'd0,  5'd0,  1'b1, 1'b0},
        // matching self loops on the top vertex, operands set on evaluate
        '{ACT_ADD_A,   5'd31, 5'd31, 1'b0, 1'b0},
        '{ACT_ADD_B,   5'd31, 5'd31, 1'b0, 1'b0},
        '{ACT_EVAL,    5'd31, 5'd31, 1'b1, 1'b1},
        // unused action code leaves both graphs empty
        '{ACT_IGNORED, 5'd31, 5'd31, 1'b0, 1'b0},
        '{ACT_EVAL,    5'd0,  5'd0,  1'b1, 1'b1},
        // chain against chain plus its shortcut
        '{ACT_ADD_A,   5'd0,  5'd1,  1'b0, 1'b0},
        '{ACT_ADD_A,   5'd1,  5'd2,  1'b0, 1'b0},
        '{ACT_ADD_B,   5'd0,  5'd1,  1'b0, 1'b0},
        '{ACT_ADD_B,   5'd1,  5'd2,  1'b0, 1'b0},
        '{ACT_ADD_B,   5'd0,  5'd2,  1'b0, 1'b0},
        '{ACT_EVAL,    5'd0,  5'd0,  1'b0, 1'b0},
        // duplicate edge changes nothing
        '{ACT_ADD_A,   5'd5,  5'd6,  1'b0, 1'b0},
        '{ACT_ADD_A,   5'd5,  5'd6,  1'b0, 1'b0},
        '{ACT_ADD_B,   5'd5,  5'd6,  1'b0, 1'b0},
        '{ACT_EVAL,    5'd0,  5'd0,  1'b1, 1'b1},
        // two-vertex cycle against cycle plus a self loop
        '{ACT_ADD_A,   5'd3,  5'd4,  1'b0, 1'b0},
        '{ACT_ADD_A,   5'd4,  5'd3,  1'b0, 1'b0},
        '{ACT_ADD_B,   5'd3,  5'd4,  1'b0, 1'b0},
        '{ACT_ADD_B,   5'd4,  5'd3,  1'b0, 1'b0},
        '{ACT_ADD_B,   5'd4,  5'd4,  1'b0, 1'b0},
        '{ACT_EVAL,    5'd17, 5'd8,  1'b0, 1'b0},
        // reversed edge is not the same closure
        '{ACT_ADD_A,   5'd10, 5'd20, 1'b0, 1'b0},
        '{ACT_ADD_B,   5'd20, 5'd10, 1'b0, 1'b0}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [ACTION_W-1:0] action;
    logic [NODE_W-1:0]   src_node;
    logic [NODE_W-1:0]   dst_node;
    logic                out_valid;
    logic                out_stall;
    logic                equivalent;

    // predictor state: the two adjacency matrices
    reach_row_t reach_a [NODES];
    reach_row_t reach_b [NODES];

    logic         equiv_expected [$];
    typed_equiv_t typed_equiv [$];
    int           mismatches;
    logic         tx_calm;
    logic         rx_calm;
    int           words_sent;
    int           evals_sent;

    transitive_closure_compare #(
        .NODES(NODES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .src_node   (src_node),
        .dst_node   (dst_node),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .equivalent (equivalent)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // warshall on copies of both matrices, then a row by row compare
    function automatic logic closures_equal();
        reach_row_t ra [NODES];
        reach_row_t rb [NODES];
        logic       same;
        ra = reach_a;
        rb = reach_b;
        for (int k = 0; k < NODES; k++)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                if (ra[i][k])
                    ra[i] = ra[i] | ra[k];
                if (rb[i][k])
                    rb[i] = rb[i] | rb[k];
            end
        end
        same = 1'b1;
        for (int i = 0; i < NODES; i++)
        begin
            if (ra[i] != rb[i])
                same = 1'b0;
        end
        return same;
    endfunction

    // update the predictor with one accepted word
    task automatic take_word(input logic [ACTION_W-1:0] a, input logic [NODE_W-1:0] s,
                             input logic [NODE_W-1:0] d, input typed_equiv_t note);
        logic predicted;
        if (a == ACT_ADD_A || a == ACT_ADD_B)
        begin
            // an index past the last vertex is dropped
            if (int'(s) < NODES && int'(d) < NODES)
            begin
                if (a == ACT_ADD_A)
                    reach_a[s][d] = 1'b1;
                else
                    reach_b[s][d] = 1'b1;
            end
        end
        else if (a == ACT_EVAL)
        begin
            predicted = closures_equal();
            for (int i = 0; i < NODES; i++)
            begin
                reach_a[i] = '0;
                reach_b[i] = '0;
            end
            equiv_expected.push_back(note.typed ? note.value : predicted);
        end
    endtask

    // watch both channels at every edge; values read here are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                take_word(action, src_node, dst_node,
                          typed_equiv.size() != 0 ? typed_equiv.pop_front() : '0);
            if (out_valid && !out_stall)
            begin
                if (equiv_expected.size() == 0)
                begin
                    $error("equivalent: expected none, actual %0d", equivalent);
                    mismatches++;
                end
                else if (equivalent !== equiv_expected[0])
                begin
                    $error("equivalent: expected %0d, actual %0d",
                           equiv_expected[0], equivalent);
                    mismatches++;
                    void'(equiv_expected.pop_front());
                end
                else
                    void'(equiv_expected.pop_front());
            end
        end
    end

    // receiving side: stall each result word for a drawn number of cycles
    initial
    begin : receiver
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                rx_calm = ~rx_calm;
            n = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            out_stall <= (n > 0);
            do
                @(posedge clk);
            while (!out_valid);
            if (n > 0)
            begin
                // the first stalled edge has just passed
                repeat (n - 1) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // one word on the input channel; returns at the edge that takes it
    task automatic send_word(input logic [ACTION_W-1:0] a, input logic [NODE_W-1:0] s,
                             input logic [NODE_W-1:0] d);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action   <= a;
        src_node <= s;
        dst_node <= d;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // hold the sender until every predicted result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (equiv_expected.size() != 0);
    endtask

    function automatic int pick_node(input int base, input int span);
        return base + $urandom_range(0, span);
    endfunction

    // one random case: edges for both graphs, interleaved, then an evaluate
    task automatic send_case();
        int a_src [$];
        int a_dst [$];
        int b_src [$];
        int b_dst [$];
        int span;
        int base;
        int m;
        int mode;
        int pick;
        logic swap;
        logic to_b;
        logic [ACTION_W-1:0] code;
        // a narrow vertex window makes chains and cycles likely
        span = ($urandom_range(0, 3) == 0) ? NODES - 1 : $urandom_range(1, 7);
        base = $urandom_range(0, NODES - 1 - span);
        m = $urandom_range(0, 8);
        for (int j = 0; j < m; j++)
        begin
            a_src.push_back(pick_node(base, span));
            a_dst.push_back(pick_node(base, span));
        end
        mode = $urandom_range(0, 3);
        if (mode <= 1)
        begin
            // same closure: the same edges plus some shortcuts the closure implies
            b_src = a_src;
            b_dst = a_dst;
            for (int j = 0; j < m; j++)
            begin
                for (int l = 0; l < m; l++)
                begin
                    if (a_dst[j] == a_src[l] && $urandom_range(0, 1) == 1)
                    begin
                        b_src.push_back(a_src[j]);
                        b_dst.push_back(a_dst[l]);
                    end
                end
            end
            if (m > 0 && $urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, m - 1);
                a_src.push_back(a_src[pick]);
                a_dst.push_back(a_dst[pick]);
            end
        end
        else if (mode == 2)
        begin
            // nearly the same: one extra edge on one side
            b_src = a_src;
            b_dst = a_dst;
            b_src.push_back(pick_node(base, span));
            b_dst.push_back(pick_node(base, span));
        end
        else
        begin
            // unrelated graph
            m = $urandom_range(0, 8);
            for (int j = 0; j < m; j++)
            begin
                b_src.push_back(pick_node(base, span));
                b_dst.push_back(pick_node(base, span));
            end
        end
        swap = 1'($urandom_range(0, 1));
        while (a_src.size() != 0 || b_src.size() != 0)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(ACT_IGNORED, NODE_W'($urandom_range(0, 31)),
                          NODE_W'($urandom_range(0, 31)));
            if (a_src.size() == 0)
                to_b = 1'b1;
            else if (b_src.size() == 0)
                to_b = 1'b0;
            else
                to_b = 1'($urandom_range(0, 1));
            code = (to_b ^ swap) ? ACT_ADD_B : ACT_ADD_A;
            if (to_b)
                send_word(code, NODE_W'(b_src.pop_front()), NODE_W'(b_dst.pop_front()));
            else
                send_word(code, NODE_W'(a_src.pop_front()), NODE_W'(a_dst.pop_front()));
            words_sent++;
        end
        send_word(ACT_EVAL, NODE_W'($urandom_range(0, 31)), NODE_W'($urandom_range(0, 31)));
        words_sent++;
        evals_sent++;
    endtask

    initial
    begin
        // every input known from time zero
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_ADD_A;
        src_node   = '0;
        dst_node   = '0;
        out_stall  = 1'b0;
        mismatches = 0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        words_sent = 0;
        evals_sent = 0;
        for (int i = 0; i < NODES; i++)
        begin
            reach_a[i] = '0;
            reach_b[i] = '0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, typed results queued alongside in word order
        for (int r = 0; r < DIR_N; r++)
        begin
            typed_equiv.push_back('{DIRECTED[r].typed, DIRECTED[r].value});
            send_word(DIRECTED[r].act, DIRECTED[r].src, DIRECTED[r].dst);
        end
        // last directed case checked against the predictor
        typed_equiv.push_back('0);
        send_word(ACT_EVAL, 5'd31, 5'd0);

        // sender holds off until the directed results are all in
        drain_results();

        // random cases until enough words and enough evaluates have gone
        while (words_sent < RANDOM_WORDS || evals_sent < MIN_EVALS)
        begin
            if ($urandom_range(0, 3) == 0)
                tx_calm = ~tx_calm;
            send_case();
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end

        drain_results();
        // let any late word show before the verdict
        repeat (EVAL_CYCLES) @(posedge clk);

        if (mismatches == 0 && equiv_expected.size() == 0)
            $display("[transitive_closure_compare] OK");
        else
        begin
            if (equiv_expected.size() != 0)
                $error("equivalent: expected %0d more results, actual none",
                       equiv_expected.size());
            $display("[transitive_closure_compare] ERROR");
        end
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial
    begin
        #30_000_000;
        $display("[transitive_closure_compare] ERROR");
        $finish;
    end

endmodule
